@@ rtl/core/sorted_array_priority_queue_unit_defines.svh @@
// Assertion macros for the sorted array priority queue's port checker.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define SAPQ_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset names.
`define SAPQ_ASSERT(lbl, prop, msg) \
   `SAPQ_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

@@ rtl/core/sapq_pkg.sv @@
// Shared widths, codes, state type and control structs of the priority queue.
`default_nettype none

package sapq_pkg;

   localparam int KEY_W         = 32;
   localparam int TAG_W         = 32;
   localparam int MODE_W        = 2;
   localparam int IDX_W         = 6;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 7;
   localparam int DEPTH_DEFAULT = 64;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic ptr_init;
      logic ptr_dec;
      logic rd_top;
      logic rd_index;
      logic rd_scan;
      logic wr_shift;
      logic wr_new_scan;
      logic wr_new_zero;
      logic cnt_inc;
      logic cnt_dec;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_remove;
      logic is_read;
      logic full;
      logic empty;
      logic idx_ok;
      logic key_ge;
      logic ptr_zero;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/core/sorted_array_priority_queue_unit.sv @@
// Bounded priority queue of DEPTH entries held in one single-port-style memory sorted ascending
// by signed key: insert places a new entry below all stored entries with an equal key, remove
// pops the entry with the largest key, and read returns the entry at a position (0 is the
// smallest key). Every request transaction gives exactly one response transaction with status
// and fill level. Requests are taken one at a time. Remove, read, mode 3 and rejected requests
// go from acceptance straight to the done state, which loads the result into the output register.
// An insert walks down from the top entry, reading an entry and then moving it up one place
// through the memory's single read and write port, until it meets a smaller key or reaches the
// bottom; an insert into an empty queue writes position 0 directly. While the previous response
// still waits in the output register, a finished request waits in the done state. The memory
// needs no clearing after reset; only stored positions are ever read. The response sits in an
// output register, so a stalled response does not block the next request from being accepted.
`default_nettype none

module sorted_array_priority_queue_unit #(
   parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [sapq_pkg::MODE_W-1:0]   req_mode,
   input  wire logic signed [sapq_pkg::KEY_W-1:0]    req_new_key,
   input  wire logic        [sapq_pkg::TAG_W-1:0]    req_new_tag,
   input  wire logic        [sapq_pkg::IDX_W-1:0]    req_read_index,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed      [sapq_pkg::KEY_W-1:0]    rsp_out_key,
   output logic             [sapq_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic                                      rsp_out_valid,
   output logic             [sapq_pkg::STATUS_W-1:0] rsp_status,
   output logic             [sapq_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic                                      rsp_is_empty,
   output logic                                      rsp_is_full
);

   sapq_pkg::cmd_type  cmd;
   sapq_pkg::stat_type stat;

   sapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sapq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_new_key     (req_new_key),
      .req_new_tag     (req_new_tag),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule

`default_nettype wire

@@ rtl/core/sapq_ctrl.sv @@
// Sequencing state machine of the priority queue.
`default_nettype none

module sapq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire sapq_pkg::stat_type stat,
   output sapq_pkg::cmd_type       cmd
);

   sapq_pkg::state_type state_ff;
   sapq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sapq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sapq_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (stat.is_insert && !stat.full) begin
                  state_in = stat.empty ? sapq_pkg::ST_INS_PUT : sapq_pkg::ST_INS_RD;
               end else begin
                  state_in = sapq_pkg::ST_DONE;
               end
            end
         end
         sapq_pkg::ST_INS_RD: begin
            state_in = sapq_pkg::ST_INS_CMP;
         end
         sapq_pkg::ST_INS_CMP: begin
            if (stat.key_ge) begin
               state_in = stat.ptr_zero ? sapq_pkg::ST_INS_PUT : sapq_pkg::ST_INS_RD;
            end else begin
               state_in = sapq_pkg::ST_DONE;
            end
         end
         sapq_pkg::ST_INS_PUT: begin
            state_in = sapq_pkg::ST_DONE;
         end
         sapq_pkg::ST_DONE: begin
            if (stat.out_free) begin
               state_in = sapq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sapq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         sapq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.ptr_init = stat.is_insert && !stat.full && !stat.empty;
               cmd.rd_top   = stat.is_remove && !stat.empty;
               cmd.cnt_dec  = stat.is_remove && !stat.empty;
               cmd.rd_index = stat.is_read && stat.idx_ok;
            end
         end
         sapq_pkg::ST_INS_RD: begin
            cmd.rd_scan = 1'b1;
         end
         sapq_pkg::ST_INS_CMP: begin
            // Larger or equal keys move up one place; the first smaller key ends the scan.
            if (stat.key_ge) begin
               cmd.wr_shift = 1'b1;
               cmd.ptr_dec  = !stat.ptr_zero;
            end else begin
               cmd.wr_new_scan = 1'b1;
               cmd.cnt_inc     = 1'b1;
            end
         end
         sapq_pkg::ST_INS_PUT: begin
            cmd.wr_new_zero = 1'b1;
            cmd.cnt_inc     = 1'b1;
         end
         sapq_pkg::ST_DONE: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/sapq_datapath.sv @@
// Entry memory, fill count, scan pointer and result register of the priority queue.
`default_nettype none

module sapq_datapath #(
   parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sapq_pkg::cmd_type                    cmd,
   output sapq_pkg::stat_type                        stat,
   input  wire logic        [sapq_pkg::MODE_W-1:0]   req_mode,
   input  wire logic signed [sapq_pkg::KEY_W-1:0]    req_new_key,
   input  wire logic        [sapq_pkg::TAG_W-1:0]    req_new_tag,
   input  wire logic        [sapq_pkg::IDX_W-1:0]    req_read_index,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed      [sapq_pkg::KEY_W-1:0]    rsp_out_key,
   output logic             [sapq_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic                                      rsp_out_valid,
   output logic             [sapq_pkg::STATUS_W-1:0] rsp_status,
   output logic             [sapq_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic                                      rsp_is_empty,
   output logic                                      rsp_is_full
);

   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > sapq_pkg::IDX_W) ? CNT_W : sapq_pkg::IDX_W;
   localparam int DATA_W = sapq_pkg::KEY_W + sapq_pkg::TAG_W;

   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [AW-1:0]    ptr_ff;
   logic [AW-1:0]    ptr_in;

   logic signed [sapq_pkg::KEY_W-1:0]    op_key_ff;
   logic signed [sapq_pkg::KEY_W-1:0]    op_key_in;
   logic        [sapq_pkg::TAG_W-1:0]    op_tag_ff;
   logic        [sapq_pkg::TAG_W-1:0]    op_tag_in;
   logic        [sapq_pkg::STATUS_W-1:0] res_status_ff;
   logic        [sapq_pkg::STATUS_W-1:0] res_status_in;
   logic                                 res_valid_ff;
   logic                                 res_valid_in;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic signed [sapq_pkg::KEY_W-1:0]    rsp_key_ff;
   logic signed [sapq_pkg::KEY_W-1:0]    rsp_key_in;
   logic        [sapq_pkg::TAG_W-1:0]    rsp_tag_ff;
   logic        [sapq_pkg::TAG_W-1:0]    rsp_tag_in;
   logic                                 rsp_out_valid_ff;
   logic                                 rsp_out_valid_in;
   logic        [sapq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic        [sapq_pkg::STATUS_W-1:0] rsp_status_in;
   logic        [sapq_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic        [sapq_pkg::COUNT_W-1:0]  rsp_count_in;
   logic                                 rsp_empty_ff;
   logic                                 rsp_empty_in;
   logic                                 rsp_full_ff;
   logic                                 rsp_full_in;

   logic                                 rd_en;
   logic [AW-1:0]                        rd_addr;
   logic                                 wr_en;
   logic [AW-1:0]                        wr_addr;
   logic [DATA_W-1:0]                    wr_data;
   logic [AW-1:0]                        ptr_up;
   logic signed [sapq_pkg::KEY_W-1:0]    rd_key;
   logic                                 full;
   logic                                 empty;

   assign ptr_up = ptr_ff + AW'(1);
   assign rd_key = rdata_ff[DATA_W-1 -: sapq_pkg::KEY_W];
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      stat           = '0;
      stat.is_insert = (req_mode == sapq_pkg::MODE_INSERT);
      stat.is_remove = (req_mode == sapq_pkg::MODE_REMOVE);
      stat.is_read   = (req_mode == sapq_pkg::MODE_READ);
      stat.full      = full;
      stat.empty     = empty;
      stat.idx_ok    = (CMP_W'(req_read_index) < CMP_W'(count_ff));
      stat.key_ge    = (rd_key >= op_key_ff);
      stat.ptr_zero  = (ptr_ff == '0);
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Memory ports: one read and one write address per cycle.
   always_comb begin
      rd_en   = cmd.rd_top || cmd.rd_index || cmd.rd_scan;
      rd_addr = ptr_ff;
      if (cmd.rd_top) begin
         rd_addr = AW'(count_ff - CNT_W'(1));
      end else if (cmd.rd_index) begin
         rd_addr = AW'(req_read_index);
      end
      wr_en   = cmd.wr_shift || cmd.wr_new_scan || cmd.wr_new_zero;
      wr_addr = cmd.wr_new_zero ? '0 : ptr_up;
      wr_data = cmd.wr_shift ? rdata_ff : {op_key_ff, op_tag_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      ptr_in = ptr_ff;
      if (cmd.ptr_init) begin
         ptr_in = AW'(count_ff - CNT_W'(1));
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - AW'(1);
      end
   end

   always_comb begin
      op_key_in     = op_key_ff;
      op_tag_in     = op_tag_ff;
      res_status_in = res_status_ff;
      res_valid_in  = res_valid_ff;
      if (cmd.load_req) begin
         op_key_in     = req_new_key;
         op_tag_in     = req_new_tag;
         res_valid_in  = cmd.rd_top || cmd.rd_index;
         res_status_in = sapq_pkg::STATUS_OK;
         if (stat.is_insert && full) begin
            res_status_in = sapq_pkg::STATUS_FULL;
         end else if (stat.is_remove && empty) begin
            res_status_in = sapq_pkg::STATUS_EMPTY;
         end else if (stat.is_read && !stat.idx_ok) begin
            res_status_in = sapq_pkg::STATUS_RANGE;
         end
      end
   end

   // The output register frees the request side while a transaction waits to be taken.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_key_in       = rsp_key_ff;
      rsp_tag_in       = rsp_tag_ff;
      rsp_out_valid_in = rsp_out_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_empty_in     = rsp_empty_ff;
      rsp_full_in      = rsp_full_ff;
      if (cmd.out_load) begin
         rsp_valid_in     = 1'b1;
         rsp_key_in       = res_valid_ff ? rd_key : '0;
         rsp_tag_in       = res_valid_ff ? rdata_ff[sapq_pkg::TAG_W-1:0] : '0;
         rsp_out_valid_in = res_valid_ff;
         rsp_status_in    = res_status_ff;
         rsp_count_in     = sapq_pkg::COUNT_W'(count_ff);
         rsp_empty_in     = empty;
         rsp_full_in      = full;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff           <= ptr_in;
      op_key_ff        <= op_key_in;
      op_tag_ff        <= op_tag_in;
      res_status_ff    <= res_status_in;
      res_valid_ff     <= res_valid_in;
      rsp_key_ff       <= rsp_key_in;
      rsp_tag_ff       <= rsp_tag_in;
      rsp_out_valid_ff <= rsp_out_valid_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_empty_ff     <= rsp_empty_in;
      rsp_full_ff      <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_out_valid   = rsp_out_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

endmodule

`default_nettype wire

@@ rtl/core/sapq_checker.sv @@
// Port-level checks on the priority queue's responses, bound to the top level.
`default_nettype none

`include "sorted_array_priority_queue_unit_defines.svh"

module sapq_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic signed [sapq_pkg::KEY_W-1:0]    rsp_out_key,
   input wire logic        [sapq_pkg::TAG_W-1:0]    rsp_out_tag,
   input wire logic                                 rsp_out_valid,
   input wire logic        [sapq_pkg::STATUS_W-1:0] rsp_status,
   input wire logic        [sapq_pkg::COUNT_W-1:0]  rsp_entry_count,
   input wire logic                                 rsp_is_empty,
   input wire logic                                 rsp_is_full
);

   // A stalled response transaction keeps its valid and its payload.
   `SAPQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_key) && $stable(rsp_out_tag) && $stable(rsp_status) && $stable(rsp_entry_count), "stalled response changed")

   // Responses without an entry carry zero key and tag; those with one report success.
   `SAPQ_ASSERT(a_no_entry_zero, rsp_valid && !rsp_out_valid |-> rsp_out_key == '0 && rsp_out_tag == '0, "entry fields not zero")
   `SAPQ_ASSERT(a_entry_ok, rsp_valid && rsp_out_valid |-> rsp_status == sapq_pkg::STATUS_OK && !(rsp_is_empty && rsp_status == sapq_pkg::STATUS_RANGE), "entry with error status")

   // Fill flags agree with the status and count.
   `SAPQ_ASSERT(a_flags, rsp_valid |-> !(rsp_is_empty && rsp_is_full) && (!rsp_is_empty || rsp_entry_count == '0) && (rsp_status != sapq_pkg::STATUS_FULL || rsp_is_full) && (rsp_status != sapq_pkg::STATUS_EMPTY || rsp_is_empty), "fill flags inconsistent")

endmodule

bind sorted_array_priority_queue_unit sapq_checker u_sapq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_key     (rsp_out_key),
   .rsp_out_tag     (rsp_out_tag),
   .rsp_out_valid   (rsp_out_valid),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_is_full     (rsp_is_full)
);

`default_nettype wire

@@ dv/sorted_array_priority_queue_unit_checker.sv @@
// Checker for the priority queue: mirrors the sorted store and compares every response.
`timescale 1ns / 100ps

module sorted_array_priority_queue_unit_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic        [sapq_pkg::MODE_W-1:0]   req_mode,
   input  logic signed [sapq_pkg::KEY_W-1:0]    req_new_key,
   input  logic        [sapq_pkg::TAG_W-1:0]    req_new_tag,
   input  logic        [sapq_pkg::IDX_W-1:0]    req_read_index,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [sapq_pkg::KEY_W-1:0]    rsp_out_key,
   input  logic        [sapq_pkg::TAG_W-1:0]    rsp_out_tag,
   input  logic                                 rsp_out_valid,
   input  logic        [sapq_pkg::STATUS_W-1:0] rsp_status,
   input  logic        [sapq_pkg::COUNT_W-1:0]  rsp_entry_count,
   input  logic                                 rsp_is_empty,
   input  logic                                 rsp_is_full,
   output int                                   mismatch_count,
   output int                                   pending_count
);

   localparam int DEPTH = sapq_pkg::DEPTH_DEFAULT;

   typedef struct packed {
      logic signed [sapq_pkg::KEY_W-1:0]    key;
      logic        [sapq_pkg::TAG_W-1:0]    tag;
      logic                                 hit;
      logic        [sapq_pkg::STATUS_W-1:0] status;
      logic        [sapq_pkg::COUNT_W-1:0]  count;
      logic                                 empty;
      logic                                 full;
   } queue_result_type;

   logic signed [sapq_pkg::KEY_W-1:0] key_mirror [DEPTH];
   logic        [sapq_pkg::TAG_W-1:0] tag_mirror [DEPTH];
   int                                fill;
   queue_result_type                  results_due [$];

   // Applies one operation to the mirrored store and returns the response it should give.
   function automatic queue_result_type apply_queue_op(logic [sapq_pkg::MODE_W-1:0] mode,
                                                       logic signed [sapq_pkg::KEY_W-1:0] key,
                                                       logic [sapq_pkg::TAG_W-1:0] tag,
                                                       logic [sapq_pkg::IDX_W-1:0] idx);
      queue_result_type res;
      int pos;
      res = '0;
      case (mode)
         sapq_pkg::MODE_INSERT: begin
            if (fill >= DEPTH) begin
               res.status = sapq_pkg::STATUS_FULL;
            end else begin
               // A new key lands below every stored key equal to it.
               pos = 0;
               while (pos < fill && key_mirror[pos] < key) pos++;
               for (int i = fill; i > pos; i--) begin
                  key_mirror[i] = key_mirror[i-1];
                  tag_mirror[i] = tag_mirror[i-1];
               end
               key_mirror[pos] = key;
               tag_mirror[pos] = tag;
               fill++;
            end
         end
         sapq_pkg::MODE_REMOVE: begin
            if (fill == 0) begin
               res.status = sapq_pkg::STATUS_EMPTY;
            end else begin
               fill--;
               res.key = key_mirror[fill];
               res.tag = tag_mirror[fill];
               res.hit = 1'b1;
            end
         end
         sapq_pkg::MODE_READ: begin
            if (idx >= fill) begin
               res.status = sapq_pkg::STATUS_RANGE;
            end else begin
               res.key = key_mirror[idx];
               res.tag = tag_mirror[idx];
               res.hit = 1'b1;
            end
         end
         default: ;
      endcase
      res.count = sapq_pkg::COUNT_W'(fill);
      res.empty = (fill == 0);
      res.full  = (fill == DEPTH);
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         fill = 0;
         results_due.delete();
         pending_count <= 0;
      end else begin
         // Responses are handled first: one accepted in the same cycle as a request
         // always belongs to an earlier transaction.
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               report_mismatch("response transaction with no request outstanding");
            end else begin
               want = results_due.pop_front();
               if (rsp_out_key !== want.key)
                  report_mismatch($sformatf("out_key got %h, expected %h",
                                            rsp_out_key, want.key));
               if (rsp_out_tag !== want.tag)
                  report_mismatch($sformatf("out_tag got %h, expected %h",
                                            rsp_out_tag, want.tag));
               if (rsp_out_valid !== want.hit)
                  report_mismatch($sformatf("out_valid got %b, expected %b",
                                            rsp_out_valid, want.hit));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_entry_count !== want.count)
                  report_mismatch($sformatf("entry_count got %0d, expected %0d",
                                            rsp_entry_count, want.count));
               if (rsp_is_empty !== want.empty)
                  report_mismatch($sformatf("is_empty got %b, expected %b",
                                            rsp_is_empty, want.empty));
               if (rsp_is_full !== want.full)
                  report_mismatch($sformatf("is_full got %b, expected %b",
                                            rsp_is_full, want.full));
            end
         end
         if (req_valid && req_ready)
            results_due.push_back(apply_queue_op(req_mode, req_new_key, req_new_tag,
                                                 req_read_index));
         pending_count <= results_due.size();
      end
   end

endmodule

@@ dv/sorted_array_priority_queue_unit_tb.sv @@
// Testbench top for the priority queue: clock, reset, request stimulus, response sink, verdict.
`timescale 1ns / 100ps

module sorted_array_priority_queue_unit_tb;

   localparam logic [sapq_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int SEGMENTS        = 8;
   localparam int SEGMENT_ITEMS   = 106;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef enum int {MIX_FILL, MIX_LOOKUP, MIX_DRAIN, MIX_BALANCED} op_mix_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic        [sapq_pkg::MODE_W-1:0]   req_mode = sapq_pkg::MODE_INSERT;
   logic signed [sapq_pkg::KEY_W-1:0]    req_new_key = '0;
   logic        [sapq_pkg::TAG_W-1:0]    req_new_tag = '0;
   logic        [sapq_pkg::IDX_W-1:0]    req_read_index = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [sapq_pkg::KEY_W-1:0]    rsp_out_key;
   logic        [sapq_pkg::TAG_W-1:0]    rsp_out_tag;
   logic                                 rsp_out_valid;
   logic        [sapq_pkg::STATUS_W-1:0] rsp_status;
   logic        [sapq_pkg::COUNT_W-1:0]  rsp_entry_count;
   logic                                 rsp_is_empty;
   logic                                 rsp_is_full;
   int                                   mismatch_count;
   int                                   pending_count;
   int                                   stalled_cycles = 0;
   bit                                   sender_quiet = 1'b0;
   bit                                   hold_off_pending = 1'b0;

   sorted_array_priority_queue_unit dut (.*);

   sorted_array_priority_queue_unit_checker queue_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // Holds valid and payload steady until the request transaction is taken.
   task automatic offer_request(logic [sapq_pkg::MODE_W-1:0] mode,
                                logic signed [sapq_pkg::KEY_W-1:0] key,
                                logic [sapq_pkg::TAG_W-1:0] tag,
                                logic [sapq_pkg::IDX_W-1:0] idx);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_new_key    <= key;
      req_new_tag    <= tag;
      req_read_index <= idx;
      do @(posedge clock); while (!req_ready);
   endtask

   // Small keys collide often, which exercises the ordering among equal keys.
   function automatic logic signed [sapq_pkg::KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll < 3) return int'($urandom_range(0, 10)) - 5;
      if (roll == 3) return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      return $urandom();
   endfunction

   task automatic offer_random_request(op_mix_type mix);
      int insert_pct;
      int remove_pct;
      int roll;
      logic [sapq_pkg::MODE_W-1:0] mode;
      logic [sapq_pkg::IDX_W-1:0] idx;
      case (mix)
         MIX_FILL:   begin insert_pct = 88; remove_pct = 4;  end
         MIX_LOOKUP: begin insert_pct = 20; remove_pct = 15; end
         MIX_DRAIN:  begin insert_pct = 8;  remove_pct = 80; end
         default:    begin insert_pct = 45; remove_pct = 35; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) mode = sapq_pkg::MODE_INSERT;
      else if (roll < insert_pct + remove_pct) mode = sapq_pkg::MODE_REMOVE;
      else if (roll >= 97) mode = MODE_UNUSED;
      else mode = sapq_pkg::MODE_READ;
      idx = ($urandom_range(0, 1) != 0) ? sapq_pkg::IDX_W'($urandom_range(0, 63))
                                        : sapq_pkg::IDX_W'($urandom_range(0, 15));
      offer_request(mode, pick_key(), $urandom(), idx);
   endtask

   initial begin : request_source
      op_mix_type mix;
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: remove, read and the unused mode.
      offer_request(sapq_pkg::MODE_REMOVE, '0, '0, '0);
      offer_request(sapq_pkg::MODE_READ, '0, '0, '0);
      offer_request(MODE_UNUSED, -1, 32'hFFFF_FFFF, 6'd63);
      // Extremes of the key and tag, then repeated keys.
      offer_request(sapq_pkg::MODE_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, '0);
      offer_request(sapq_pkg::MODE_INSERT, 32'sh8000_0000, 32'h0000_0000, 6'd63);
      offer_request(sapq_pkg::MODE_INSERT, 0, 32'h5555_5555, '0);
      offer_request(sapq_pkg::MODE_INSERT, 0, 32'hAAAA_AAAA, '0);
      offer_request(sapq_pkg::MODE_INSERT, -1, 32'h0000_0001, '0);
      offer_request(sapq_pkg::MODE_INSERT, 32'sh7FFF_FFFF, 32'h0000_0002, '0);
      offer_request(sapq_pkg::MODE_READ, '0, '0, 6'd0);
      offer_request(sapq_pkg::MODE_READ, '0, '0, 6'd2);
      offer_request(sapq_pkg::MODE_READ, '0, '0, 6'd3);
      offer_request(sapq_pkg::MODE_READ, '0, '0, 6'd5);
      offer_request(sapq_pkg::MODE_READ, '0, '0, 6'd6);
      offer_request(sapq_pkg::MODE_READ, '0, '0, 6'd63);
      offer_request(MODE_UNUSED, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 6'd1);
      // The two largest keys are equal, so the older one must come out first.
      repeat (7) offer_request(sapq_pkg::MODE_REMOVE, '0, '0, '0);

      // The first segments fill the queue past full, look it over, then drain it.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 3) begin
            mix = op_mix_type'(seg == 0 ? MIX_FILL : (seg == 1 ? MIX_LOOKUP : MIX_DRAIN));
         end else begin
            mix = op_mix_type'($urandom_range(0, 3));
         end
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            if (n % 50 == 0) sender_quiet = ($urandom_range(0, 2) == 0);
            if (seg == 0 && n == 30) hold_off_pending = 1'b1;
            offer_random_request(mix);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : response_sink
      int stall;
      int served;
      bit sink_quiet;
      served = 0;
      sink_quiet = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (served % 40 == 0) sink_quiet = ($urandom_range(0, 2) == 0);
         // A long hold-off lets the output register and the request side back up.
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end else begin
            stall = sink_quiet ? 0 : $urandom_range(0, 14);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         served++;
      end
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sapq_pkg.sv
rtl/core/sapq_ctrl.sv
rtl/core/sapq_datapath.sv
rtl/core/sorted_array_priority_queue_unit.sv
rtl/core/sapq_checker.sv
dv/sorted_array_priority_queue_unit_checker.sv
dv/sorted_array_priority_queue_unit_tb.sv
